@@ design/lwma_pkg.sv @@
// Package for the LWMA difficulty retarget core: fixed widths, register
// indexes and the wide word type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lwma_pkg;
    localparam int unsigned WideW = 256;
    localparam logic [2:0] CfgLastPowHeight = 3'd0;
    localparam logic [2:0] CfgPosSpacing    = 3'd1;
    localparam logic [2:0] CfgPowSpacing    = 3'd2;
    localparam logic [2:0] CfgPosLimitShift = 3'd3;
    localparam logic [2:0] CfgPowLimitShift = 3'd4;
    localparam logic [2:0] CfgTestNetwork   = 3'd5;
    typedef logic [WideW-1:0] t_wide;
endpackage
`default_nettype wire

@@ design/lwma_difficulty_retarget_core.sv @@
// LWMA difficulty retarget core: history shift register, bit-serial divider, shift-add
// multiplier and compact encode. Depends on lwma_pkg.
// The weighted-average rule runs one 256-step divide per window entry; the
// one-block rule runs a 64-step multiply, then a 256-step divide; the limit
// itself is the result when a limit applies. One item in flight: a new item is
// accepted only after the result is taken. Sync reset clears control.
`timescale 1ns / 1ps
`default_nettype none
module lwma_difficulty_retarget_core #(
    parameter int unsigned WINDOW = 24
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // [30:0] height, [62:31] block_time, [94:63] block_bits, [95] zero
    input  wire  [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [31:0] next_bits
    output logic [31:0] m_axis_tdata,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [31:0] i_cfg_data
);
    localparam int unsigned TW = $clog2(WINDOW + 1);
    localparam int unsigned BW = $clog2(WINDOW);
    localparam int unsigned WW = lwma_pkg::WideW;
    // N*N*(N+1)/2, the weighted-average divisor per unit of spacing
    localparam logic [23:0] KN = 24'(WINDOW * WINDOW * (WINDOW + 1) / 2);

    localparam logic [3:0] S_IDLE = 4'd0, S_PREP = 4'd1, S_LOAD = 4'd2, S_DIV = 4'd3,
                           S_ACC = 4'd4, S_MUL = 4'd5, S_PMUL = 4'd6, S_PDIV = 4'd7,
                           S_QUO = 4'd8, S_CLAMP = 4'd9, S_ENC = 4'd10, S_OUT = 4'd11;

    logic [31:0] r_time [WINDOW+1];
    logic [31:0] r_bits [WINDOW];

    logic [30:0] r_lph;
    logic [15:0] r_pos_sp, r_pow_sp;
    logic [7:0]  r_pos_sh, r_pow_sh;
    logic        r_test;

    logic [3:0]  r_st;
    logic [30:0] r_h;
    logic [TW-1:0] r_idx;
    logic [8:0]  r_cnt;
    lwma_pkg::t_wide r_num, r_q, r_sum, r_acc, r_lim;
    logic [63:0] r_rem, r_div;
    logic [63:0] r_prev, r_t;
    logic [6:0]  r_j;
    logic [63:0] r_mulb;
    logic [31:0] r_res;

    assign o_cfg_ready   = (r_st == S_IDLE);
    assign s_axis_tready = (r_st == S_IDLE) && !i_cfg_valid;
    assign m_axis_tvalid = (r_st == S_OUT);
    assign m_axis_tdata  = r_res;

    function automatic lwma_pkg::t_wide from_compact(input logic [31:0] c);
        lwma_pkg::t_wide r;
        logic [7:0] sz;
        r  = '0;
        sz = c[31:24];
        r[22:0] = c[22:0];
        if (sz <= 8'd3) r = r >> (8 * (3 - sz));
        else            r = r << (8 * (sz - 8'd3));
        return r;
    endfunction

    function automatic logic [31:0] to_compact(input lwma_pkg::t_wide a);
        logic [8:0] nb;
        logic [8:0] sz;
        logic [31:0] c;
        lwma_pkg::t_wide s;
        nb = '0;
        for (int i = 0; i < WW; i++) if (a[i]) nb = 9'(i + 1);
        sz = (nb + 9'd7) >> 3;
        if (sz <= 9'd3) s = a << (8 * (3 - sz));
        else            s = a >> (8 * (sz - 9'd3));
        c = {8'd0, s[23:0]};
        if (c[23]) begin
            c  = c >> 8;
            sz = sz + 9'd1;
        end
        return c | {sz[7:0], 24'd0};
    endfunction

    logic [63:0] w_T, w_R, w_cap, w_cur, w_st, w_lo, w_hi;
    logic [64:0] w_trial;
    logic [31:0] w_bt;
    logic signed [33:0] w_span;
    lwma_pkg::t_wide w_prod;
    assign w_T   = (r_pos_sp == 16'd0) ? 64'd1 : 64'(r_pos_sp);
    assign w_R   = (r_pow_sp == 16'd0) ? 64'd1 : 64'(r_pow_sp);
    assign w_cap = 64'd6 * w_T;
    assign w_lo  = w_R - (w_R >> 2);
    assign w_hi  = w_R + (w_R >> 1);
    assign w_bt  = r_time[r_idx];
    assign w_cur = (64'(w_bt) > r_prev) ? 64'(w_bt) : r_prev + 64'd1;
    assign w_st  = ((w_cur - r_prev) > w_cap) ? w_cap : (w_cur - r_prev);
    assign w_trial = {r_rem, r_num[WW-1]} - {1'b0, r_div};
    assign w_span = $signed({2'b0, r_time[0]}) -
                    $signed({2'b0, (r_h != 31'd0) ? r_time[1] : r_time[0]});
    // one shift-add multiply step, product wraps at the wide width
    assign w_prod = r_mulb[0] ? r_acc + r_num : r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_lph <= '0; r_pos_sp <= 16'd60; r_pow_sp <= 16'd60;
            r_pos_sh <= 8'd20; r_pow_sh <= 8'd20; r_test <= 1'b0;
        end else begin
            unique case (r_st)
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        unique case (i_cfg_index)
                            lwma_pkg::CfgLastPowHeight: r_lph    <= i_cfg_data[30:0];
                            lwma_pkg::CfgPosSpacing:    r_pos_sp <= i_cfg_data[15:0];
                            lwma_pkg::CfgPowSpacing:    r_pow_sp <= i_cfg_data[15:0];
                            lwma_pkg::CfgPosLimitShift: r_pos_sh <= i_cfg_data[7:0];
                            lwma_pkg::CfgPowLimitShift: r_pow_sh <= i_cfg_data[7:0];
                            lwma_pkg::CfgTestNetwork:   r_test   <= i_cfg_data[0];
                            default: ;
                        endcase
                    end
                    if (s_axis_tvalid && s_axis_tready) begin
                        for (int i = WINDOW; i > 0; i--) r_time[i] <= r_time[i-1];
                        for (int i = WINDOW - 1; i > 0; i--) r_bits[i] <= r_bits[i-1];
                        r_time[0] <= s_axis_tdata[62:31];
                        r_bits[0] <= s_axis_tdata[94:63];
                        r_h  <= s_axis_tdata[30:0];
                        r_st <= S_PREP;
                    end
                end
                S_PREP: begin
                    if (32'(r_h) + 32'd1 > 32'(r_lph)) begin
                        r_lim <= {WW{1'b1}} >> r_pos_sh;
                        if (32'(r_h) < 32'(r_lph) + 32'(WINDOW)) begin
                            r_acc <= {WW{1'b1}} >> r_pos_sh;
                            r_st  <= S_ENC;
                        end else begin
                            r_div  <= 64'(40'(w_T[15:0]) * 40'(KN));
                            r_prev <= 64'(r_time[WINDOW]);
                            r_idx  <= TW'(WINDOW - 1);
                            r_t <= '0; r_j <= '0; r_sum <= '0;
                            r_st <= S_LOAD;
                        end
                    end else begin
                        r_lim <= {WW{1'b1}} >> r_pow_sh;
                        if (r_test) begin
                            r_acc <= {WW{1'b1}} >> r_pow_sh;
                            r_st  <= S_ENC;
                        end else begin
                            r_num <= from_compact(r_bits[0]);
                            r_mulb <= (w_span < $signed(34'(w_lo))) ? w_lo :
                                      (w_span > $signed(34'(w_hi))) ? w_hi : 64'(w_span);
                            r_acc <= '0;
                            r_cnt <= 9'd64;
                            r_st  <= S_PMUL;
                        end
                    end
                end
                S_LOAD: begin
                    r_num  <= from_compact(r_bits[r_idx[BW-1:0]]);
                    r_prev <= w_cur;
                    r_t    <= r_t + 64'(26'(w_st[18:0]) * 26'(r_j + 7'd1));
                    r_j    <= r_j + 7'd1;
                    r_rem <= '0; r_q <= '0; r_cnt <= 9'(WW);
                    r_st  <= S_DIV;
                end
                S_DIV, S_PDIV: begin
                    if (w_trial[64] == 1'b0) begin
                        r_rem <= w_trial[63:0]; r_q <= {r_q[WW-2:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[62:0], r_num[WW-1]}; r_q <= {r_q[WW-2:0], 1'b0};
                    end
                    r_num <= r_num << 1;
                    r_cnt <= r_cnt - 9'd1;
                    if (r_cnt == 9'd1) r_st <= (r_st == S_PDIV) ? S_QUO : S_ACC;
                end
                S_ACC: begin
                    r_sum <= r_sum + r_q;
                    if (r_idx == '0) begin
                        r_num <= r_sum + r_q; r_mulb <= r_t;
                        r_acc <= '0; r_cnt <= 9'd64;
                        r_st <= S_MUL;
                    end else begin
                        r_idx <= r_idx - TW'(1); r_st <= S_LOAD;
                    end
                end
                S_MUL, S_PMUL: begin
                    if (r_cnt == 9'd1 && r_st == S_PMUL) begin
                        // hand the product to the divider
                        r_num <= w_prod;
                        r_div <= w_R; r_rem <= '0; r_cnt <= 9'(WW);
                        r_st  <= S_PDIV;
                    end else begin
                        r_acc  <= w_prod;
                        r_num  <= r_num << 1;
                        r_mulb <= r_mulb >> 1;
                        r_cnt  <= r_cnt - 9'd1;
                        if (r_cnt == 9'd1) r_st <= S_CLAMP;
                    end
                end
                S_QUO: begin
                    r_acc <= r_q;
                    r_st  <= S_CLAMP;
                end
                S_CLAMP: begin
                    if (r_acc > r_lim) r_acc <= r_lim;
                    r_st <= S_ENC;
                end
                S_ENC: begin
                    r_res <= to_compact(r_acc);
                    r_st  <= S_OUT;
                end
                S_OUT: if (m_axis_tready) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
